// ----- src/beacon_ie_security_classifier_assert.svh -----
`ifndef BEACON_IE_SECURITY_CLASSIFIER_ASSERT_SVH
`define BEACON_IE_SECURITY_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define BISC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bisc assertion failed");

// next-cycle implication
`define BISC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bisc assertion failed");

`endif

// ----- src/bisc_pkg.sv -----
package bisc_pkg;

   localparam logic [7:0] ID_RSN    = 8'd48;
   localparam logic [7:0] ID_VENDOR = 8'd221;

   localparam logic [2:0] SEC_OPEN = 3'd0;
   localparam logic [2:0] SEC_WEP  = 3'd1;
   localparam logic [2:0] SEC_WPA  = 3'd2;
   localparam logic [2:0] SEC_WPA2 = 3'd3;
   localparam logic [2:0] SEC_WPA3 = 3'd4;

   localparam logic [1:0] CIPH_NONE = 2'd0;
   localparam logic [1:0] CIPH_WEP  = 2'd1;
   localparam logic [1:0] CIPH_TKIP = 2'd2;
   localparam logic [1:0] CIPH_CCMP = 2'd3;

   localparam logic [7:0] RSN_PAIRWISE_LO = 8'd6;
   localparam logic [7:0] RSN_PAIRWISE_HI = 8'd7;
   localparam logic [7:0] RSN_SUITES_MIN  = 8'd8;
   localparam logic [8:0] AKM_BASE        = 9'd10;
   localparam logic [15:0] PAIRWISE_MAX   = 16'd64;
   localparam logic [8:0] AKM_UNREACHABLE = 9'h1FF;

   typedef enum logic [2:0] {
      PH_ID   = 3'b001,
      PH_LEN  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] ie_byte;
      logic       byte_present;
      logic       last_byte;
      logic       privacy;
   } item_type;

   typedef struct packed {
      logic rsn;
      logic sae;
      logic wpa;
   } findings_type;

   function automatic logic [7:0] sae_byte(input logic [1:0] pos);
      logic [7:0] r;
      case (pos)
         2'd0: r = 8'h00;
         2'd1: r = 8'h0F;
         2'd2: r = 8'hAC;
         default: r = 8'h08;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] wpa_byte(input logic [1:0] pos);
      logic [7:0] r;
      case (pos)
         2'd0: r = 8'h00;
         2'd1: r = 8'h50;
         2'd2: r = 8'hF2;
         default: r = 8'h01;
      endcase
      return r;
   endfunction

endpackage

// ----- src/bisc_walker.sv -----
module bisc_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  bisc_pkg::item_type    item,
   output bisc_pkg::findings_type found_nx
);

   bisc_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]             id_ff, id_in;
   logic [7:0]             len_ff, len_in;
   logic [7:0]             off_ff, off_in;
   logic [7:0]             pc_lo_ff, pc_lo_in;
   logic [15:0]            akm_cnt_ff, akm_cnt_in;
   logic [8:0]             akm_start_ff, akm_start_in;
   logic [3:0]             match_ff, match_in;
   logic                   pend_sae_ff, pend_sae_in;
   logic                   pend_wpa_ff, pend_wpa_in;
   bisc_pkg::findings_type found_ff, found_in;

   always_comb begin
      logic [7:0]  b;
      logic [8:0]  off_inc;
      logic [8:0]  off_w;
      logic [7:0]  rel;
      logic [1:0]  pos;
      logic [15:0] pc_full;
      logic [3:0]  m;
      b        = item.ie_byte;
      off_inc  = {1'b0, off_ff} + 9'd1;
      off_w    = {1'b0, off_ff};
      rel      = off_ff - akm_start_ff[7:0];
      pos      = rel[1:0];
      pc_full  = {b, pc_lo_ff};
      m        = match_ff;

      phase_in     = phase_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      pc_lo_in     = pc_lo_ff;
      akm_cnt_in   = akm_cnt_ff;
      akm_start_in = akm_start_ff;
      match_in     = match_ff;
      pend_sae_in  = pend_sae_ff;
      pend_wpa_in  = pend_wpa_ff;
      found_in     = found_ff;

      if (item.byte_present) begin
         unique case (phase_ff)
            bisc_pkg::PH_ID: begin
               id_in    = b;
               phase_in = bisc_pkg::PH_LEN;
            end
            bisc_pkg::PH_LEN: begin
               len_in       = b;
               off_in       = '0;
               pc_lo_in     = '0;
               akm_cnt_in   = '0;
               akm_start_in = '0;
               match_in     = '0;
               pend_sae_in  = 1'b0;
               pend_wpa_in  = 1'b0;
               if (b == 8'd0) begin
                  if (id_ff == bisc_pkg::ID_RSN) begin
                     found_in.rsn = 1'b1;
                  end
                  phase_in = bisc_pkg::PH_ID;
               end else begin
                  phase_in = bisc_pkg::PH_BODY;
               end
            end
            bisc_pkg::PH_BODY: begin
               if (id_ff == bisc_pkg::ID_RSN) begin
                  if (off_ff == bisc_pkg::RSN_PAIRWISE_LO) begin
                     pc_lo_in = b;
                  end else if (off_ff == bisc_pkg::RSN_PAIRWISE_HI) begin
                     if (pc_full < bisc_pkg::PAIRWISE_MAX) begin
                        akm_start_in = bisc_pkg::AKM_BASE + {1'b0, pc_full[5:0], 2'b00};
                     end else begin
                        akm_start_in = bisc_pkg::AKM_UNREACHABLE;
                     end
                  end else if (off_ff >= bisc_pkg::RSN_SUITES_MIN) begin
                     if (off_w == akm_start_ff - 9'd2) begin
                        akm_cnt_in = {8'd0, b};
                     end else if (off_w == akm_start_ff - 9'd1) begin
                        akm_cnt_in = {b, akm_cnt_ff[7:0]};
                     end else if (off_w >= akm_start_ff) begin
                        if ({10'd0, rel[7:2]} < akm_cnt_ff) begin
                           if (pos == 2'd0) begin
                              m = '0;
                           end
                           if (b == bisc_pkg::sae_byte(pos)) begin
                              m[pos] = 1'b1;
                           end
                           match_in = m;
                           if (pos == 2'd3 && m == 4'hF) begin
                              pend_sae_in = 1'b1;
                           end
                        end
                     end
                  end
               end else if (id_ff == bisc_pkg::ID_VENDOR) begin
                  if (off_ff < 8'd4) begin
                     if (b == bisc_pkg::wpa_byte(off_ff[1:0])) begin
                        m[off_ff[1:0]] = 1'b1;
                     end
                     match_in = m;
                     if (off_ff[1:0] == 2'd3 && m == 4'hF) begin
                        pend_wpa_in = 1'b1;
                     end
                  end
               end

               if (off_inc >= {1'b0, len_ff}) begin
                  if (id_ff == bisc_pkg::ID_RSN) begin
                     found_in.rsn = 1'b1;
                     if (pend_sae_in) begin
                        found_in.sae = 1'b1;
                     end
                  end else if (id_ff == bisc_pkg::ID_VENDOR) begin
                     if (pend_wpa_in) begin
                        found_in.wpa = 1'b1;
                     end
                  end
                  phase_in = bisc_pkg::PH_ID;
               end else begin
                  off_in = off_inc[7:0];
               end
            end
            default: begin
               phase_in = bisc_pkg::PH_ID;
            end
         endcase
      end
   end

   assign found_nx = found_in;

   always_ff @(posedge clock) begin
      if (reset || (step && item.last_byte)) begin
         phase_ff     <= bisc_pkg::PH_ID;
         id_ff        <= '0;
         len_ff       <= '0;
         off_ff       <= '0;
         pc_lo_ff     <= '0;
         akm_cnt_ff   <= '0;
         akm_start_ff <= '0;
         match_ff     <= '0;
         pend_sae_ff  <= 1'b0;
         pend_wpa_ff  <= 1'b0;
         found_ff     <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         id_ff        <= id_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
         pc_lo_ff     <= pc_lo_in;
         akm_cnt_ff   <= akm_cnt_in;
         akm_start_ff <= akm_start_in;
         match_ff     <= match_in;
         pend_sae_ff  <= pend_sae_in;
         pend_wpa_ff  <= pend_wpa_in;
         found_ff     <= found_in;
      end
   end

endmodule

// ----- src/bisc_rsp_reg.sv -----
module bisc_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bisc_pkg::findings_type found,
   input  logic                   privacy,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_security_class,
   output logic [1:0]             rsp_cipher_class,
   output logic                   rsp_secure
);

   logic       valid_ff, valid_in;
   logic [2:0] sec_ff, sec_in;
   logic [1:0] ciph_ff, ciph_in;
   logic       secure_ff;

   always_comb begin
      if (found.rsn) begin
         sec_in  = found.sae ? bisc_pkg::SEC_WPA3 : bisc_pkg::SEC_WPA2;
         ciph_in = bisc_pkg::CIPH_CCMP;
      end else if (found.wpa) begin
         sec_in  = bisc_pkg::SEC_WPA;
         ciph_in = bisc_pkg::CIPH_TKIP;
      end else if (privacy) begin
         sec_in  = bisc_pkg::SEC_WEP;
         ciph_in = bisc_pkg::CIPH_WEP;
      end else begin
         sec_in  = bisc_pkg::SEC_OPEN;
         ciph_in = bisc_pkg::CIPH_NONE;
      end
      valid_in = load | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sec_ff    <= sec_in;
         ciph_ff   <= ciph_in;
         secure_ff <= (sec_in != bisc_pkg::SEC_OPEN);
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_security_class = sec_ff;
   assign rsp_cipher_class   = ciph_ff;
   assign rsp_secure         = secure_ff;

endmodule

// ----- src/beacon_ie_security_classifier.sv -----
// The result register loads a result word when the last input word advances.
// Throughput: one input word per cycle unless stalled; the element walker updates once per word.
// The input stalls only while a last word waits behind a result word still stalled.
// Reset (synchronous): clears the element walker, the findings and both valid flags.
`include "beacon_ie_security_classifier_assert.svh"

module beacon_ie_security_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ie_byte,
   input  logic       req_byte_present,
   input  logic       req_last_byte,
   input  logic       req_privacy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_security_class,
   output logic [1:0] rsp_cipher_class,
   output logic       rsp_secure
);

   logic                   in_valid_ff, in_valid_in;
   bisc_pkg::item_type     item_ff;
   logic                   advance;
   bisc_pkg::findings_type found_nx;

   assign advance   = in_valid_ff & (~item_ff.last_byte | ~rsp_valid | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff.ie_byte      <= req_ie_byte;
         item_ff.byte_present <= req_byte_present;
         item_ff.last_byte    <= req_last_byte;
         item_ff.privacy      <= req_privacy;
      end
   end

   bisc_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (item_ff),
      .found_nx (found_nx)
   );

   bisc_rsp_reg u_rsp (
      .clock              (clock),
      .reset              (reset),
      .load               (advance & item_ff.last_byte),
      .found              (found_nx),
      .privacy            (item_ff.privacy),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_security_class (rsp_security_class),
      .rsp_cipher_class   (rsp_cipher_class),
      .rsp_secure         (rsp_secure)
   );

   `BISC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, in_valid_ff && rsp_valid && rsp_stall)
   `BISC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, advance && item_ff.last_byte, rsp_valid)
   `BISC_ASSERT_NOW(a_secure_match, clock, reset, rsp_valid, rsp_secure == (rsp_security_class != bisc_pkg::SEC_OPEN))
   `BISC_ASSERT_NOW(a_rsn_ccmp, clock, reset, rsp_valid && (rsp_security_class == bisc_pkg::SEC_WPA3 || rsp_security_class == bisc_pkg::SEC_WPA2), rsp_cipher_class == bisc_pkg::CIPH_CCMP)

endmodule
